// ===== hw/rtl/tclp_pkg.sv =====
// Shared types, constants and helper functions for the command line parser.
// Depends on nothing; every other file uses it, the RTL files by scoped names.
package tclp_pkg;

    localparam int LINE_MAX  = 256;
    localparam int TOKEN_MAX = 31;

    localparam int COUNT_W = $clog2(LINE_MAX + 1);
    localparam int TLEN_W  = 6;
    localparam int HZ_W    = 32;

    // Parser phases.
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_WORD   = 3'd1;
    localparam logic [2:0] PH_VGAP   = 3'd2;
    localparam logic [2:0] PH_SCREEN = 3'd3;
    localparam logic [2:0] PH_VTAIL  = 3'd4;
    localparam logic [2:0] PH_TGAP   = 3'd5;
    localparam logic [2:0] PH_NUM    = 3'd6;
    localparam logic [2:0] PH_NTAIL  = 3'd7;

    // Status codes.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_EMPTY      = 4'd1;
    localparam logic [3:0] ST_TOO_LONG   = 4'd2;
    localparam logic [3:0] ST_MALFORMED  = 4'd3;
    localparam logic [3:0] ST_NO_SCREEN  = 4'd4;
    localparam logic [3:0] ST_TRAILING   = 4'd5;
    localparam logic [3:0] ST_BAD_SCREEN = 4'd6;
    localparam logic [3:0] ST_BAD_CMD    = 4'd7;
    localparam logic [3:0] ST_NO_FREQ    = 4'd8;
    localparam logic [3:0] ST_NOT_INT    = 4'd9;
    localparam logic [3:0] ST_RANGE      = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]      status;
        logic            command_kind;
        logic            screen_choice;
        logic [HZ_W-1:0] tune_hz;
    } out_item_t;

    typedef struct packed {
        logic [2:0]        parse_phase;
        logic [1:0]        token_match;
        logic [TLEN_W-1:0] token_length;
        logic              text_ended;
        logic              hz_overflow;
        logic [3:0]        latched_error;
        logic [HZ_W-1:0]   hz_accumulator;
    } parse_regs_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Character of a keyword at a position; zero past the keyword's end, which
    // never equals a token byte since a zero byte ends the text.
    function automatic logic [7:0] name_char(input logic screen, input logic k,
                                             input logic [TLEN_W-1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case ({screen, k})
            2'b00: case (pos)
                6'd0: ch = "v";
                6'd1: ch = "i";
                6'd2: ch = "e";
                6'd3: ch = "w";
                default: ch = 8'h00;
            endcase
            2'b01: case (pos)
                6'd0: ch = "t";
                6'd1: ch = "u";
                6'd2: ch = "n";
                6'd3: ch = "e";
                default: ch = 8'h00;
            endcase
            2'b10: case (pos)
                6'd0: ch = "s";
                6'd1: ch = "c";
                6'd2: ch = "o";
                6'd3: ch = "p";
                6'd4: ch = "e";
                default: ch = 8'h00;
            endcase
            default: case (pos)
                6'd0: ch = "s";
                6'd1: ch = "u";
                6'd2: ch = "r";
                6'd3: ch = "v";
                6'd4: ch = "e";
                6'd5: ch = "y";
                default: ch = 8'h00;
            endcase
        endcase
        return ch;
    endfunction

    // Returns {found, index} of the first keyword matched in full.
    function automatic logic [1:0] full_match(input logic screen, input logic [1:0] match,
                                              input logic [TLEN_W-1:0] len);
        logic [TLEN_W-1:0] len0;
        logic [TLEN_W-1:0] len1;
        logic [1:0]        res;
        len0 = screen ? TLEN_W'(5) : TLEN_W'(4);
        len1 = screen ? TLEN_W'(6) : TLEN_W'(4);
        if (match[0] && len == len0) begin
            res = 2'b10;
        end else if (match[1] && len == len1) begin
            res = 2'b11;
        end else begin
            res = 2'b00;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/tclp_feed.sv =====
// Next-state logic of the token parser for one byte of the line.
// Depends on tclp_pkg (parse_regs_t, phases, keyword helpers).
module tclp_feed (
    input  tclp_pkg::parse_regs_t cur,
    input  logic [7:0]            c,
    output tclp_pkg::parse_regs_t nxt
);

    logic                           ws;
    logic                           digit;
    logic                           opening;
    logic                           screen_set;
    logic [tclp_pkg::TLEN_W-1:0]    pos;
    logic [1:0]                     start_match;
    logic [1:0]                     grow_match;
    logic [tclp_pkg::TLEN_W-1:0]    grow_len;
    logic [tclp_pkg::HZ_W+3:0]      prod;
    logic [1:0]                     word_hit;

    always_comb
    begin
        ws          = tclp_pkg::is_ws(c);
        digit       = tclp_pkg::is_digit(c);
        opening     = (cur.parse_phase == tclp_pkg::PH_START) ||
                      (cur.parse_phase == tclp_pkg::PH_VGAP);
        screen_set  = (cur.parse_phase == tclp_pkg::PH_VGAP) ||
                      (cur.parse_phase == tclp_pkg::PH_SCREEN);
        pos         = opening ? '0 : cur.token_length;
        start_match = opening ? 2'b11 : cur.token_match;
        grow_match[0] = start_match[0] && (tclp_pkg::name_char(screen_set, 1'b0, pos) == c);
        grow_match[1] = start_match[1] && (tclp_pkg::name_char(screen_set, 1'b1, pos) == c);
        grow_len    = (&pos) ? pos : pos + 1'b1;
        // Times ten as shift-and-add, plus the new digit.
        prod = ({4'b0, cur.hz_accumulator} << 3) + ({4'b0, cur.hz_accumulator} << 1) +
               {{(tclp_pkg::HZ_W){1'b0}}, c[3:0]};
        word_hit = tclp_pkg::full_match(1'b0, cur.token_match, cur.token_length);

        nxt = cur;
        if (!cur.text_ended && cur.latched_error == tclp_pkg::ST_OK) begin
            if (c == 8'h00) begin
                nxt.text_ended = 1'b1;
            end else begin
                case (cur.parse_phase)
                    tclp_pkg::PH_START, tclp_pkg::PH_VGAP:
                    begin
                        if (!ws) begin
                            nxt.parse_phase  = screen_set ? tclp_pkg::PH_SCREEN
                                                          : tclp_pkg::PH_WORD;
                            nxt.token_match  = grow_match;
                            nxt.token_length = grow_len;
                        end
                    end
                    tclp_pkg::PH_WORD:
                    begin
                        if (ws) begin
                            if (word_hit == 2'b10) begin
                                nxt.parse_phase = tclp_pkg::PH_VGAP;
                            end else if (word_hit == 2'b11) begin
                                nxt.parse_phase = tclp_pkg::PH_TGAP;
                                // Only space and tab may separate tune from its number.
                                if (c != 8'h20 && c != 8'h09) begin
                                    nxt.latched_error = tclp_pkg::ST_NOT_INT;
                                end
                            end else begin
                                nxt.latched_error = tclp_pkg::ST_BAD_CMD;
                            end
                        end else begin
                            nxt.token_match  = grow_match;
                            nxt.token_length = grow_len;
                        end
                    end
                    tclp_pkg::PH_SCREEN:
                    begin
                        if (ws) begin
                            nxt.parse_phase = tclp_pkg::PH_VTAIL;
                        end else if (cur.token_length >= tclp_pkg::TLEN_W'(tclp_pkg::TOKEN_MAX))
                        begin
                            nxt.latched_error = tclp_pkg::ST_TRAILING;
                        end else begin
                            nxt.token_match  = grow_match;
                            nxt.token_length = grow_len;
                        end
                    end
                    tclp_pkg::PH_TGAP:
                    begin
                        if (digit) begin
                            nxt.parse_phase    = tclp_pkg::PH_NUM;
                            nxt.hz_accumulator = {{(tclp_pkg::HZ_W-4){1'b0}}, c[3:0]};
                            nxt.hz_overflow    = 1'b0;
                        end else if (c != 8'h20 && c != 8'h09) begin
                            nxt.latched_error = tclp_pkg::ST_NOT_INT;
                        end
                    end
                    tclp_pkg::PH_NUM:
                    begin
                        if (digit) begin
                            if (prod[tclp_pkg::HZ_W+3:tclp_pkg::HZ_W] != 4'd0) begin
                                nxt.hz_accumulator = '1;
                                nxt.hz_overflow    = 1'b1;
                            end else begin
                                nxt.hz_accumulator = prod[tclp_pkg::HZ_W-1:0];
                            end
                        end else if (ws) begin
                            nxt.parse_phase = tclp_pkg::PH_NTAIL;
                        end else begin
                            nxt.latched_error = tclp_pkg::ST_TRAILING;
                        end
                    end
                    default:
                    begin
                        if (!ws) begin
                            nxt.latched_error = tclp_pkg::ST_TRAILING;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/tclp_judge.sv =====
// Verdict logic: turns the judged parser state and kept length into a result.
// Depends on tclp_pkg (parse_regs_t, out_item_t, status codes).
module tclp_judge (
    input  tclp_pkg::parse_regs_t        s,
    input  logic [tclp_pkg::COUNT_W-1:0] kept_length,
    output tclp_pkg::out_item_t          verdict
);

    logic [1:0] word_hit;
    logic [1:0] screen_hit;

    always_comb
    begin
        word_hit   = tclp_pkg::full_match(1'b0, s.token_match, s.token_length);
        screen_hit = tclp_pkg::full_match(1'b1, s.token_match, s.token_length);
        verdict    = '0;
        if (kept_length == '0) begin
            verdict.status = tclp_pkg::ST_EMPTY;
        end else if (kept_length >= tclp_pkg::COUNT_W'(tclp_pkg::LINE_MAX)) begin
            verdict.status = tclp_pkg::ST_TOO_LONG;
        end else if (s.latched_error != tclp_pkg::ST_OK) begin
            verdict.status = s.latched_error;
        end else begin
            case (s.parse_phase)
                tclp_pkg::PH_START:
                    verdict.status = tclp_pkg::ST_MALFORMED;
                tclp_pkg::PH_WORD:
                begin
                    if (word_hit == 2'b10) begin
                        verdict.status = tclp_pkg::ST_NO_SCREEN;
                    end else if (word_hit == 2'b11) begin
                        verdict.status = tclp_pkg::ST_NO_FREQ;
                    end else begin
                        verdict.status = tclp_pkg::ST_BAD_CMD;
                    end
                end
                tclp_pkg::PH_VGAP:
                    verdict.status = tclp_pkg::ST_NO_SCREEN;
                tclp_pkg::PH_SCREEN, tclp_pkg::PH_VTAIL:
                begin
                    if (!screen_hit[1]) begin
                        verdict.status = tclp_pkg::ST_BAD_SCREEN;
                    end else begin
                        verdict.screen_choice = screen_hit[0];
                    end
                end
                tclp_pkg::PH_TGAP:
                    verdict.status = tclp_pkg::ST_NO_FREQ;
                default:
                begin
                    if (s.hz_overflow) begin
                        verdict.status = tclp_pkg::ST_RANGE;
                    end else begin
                        verdict.command_kind = 1'b1;
                        verdict.tune_hz      = s.hz_accumulator;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/text_command_line_parser_core.sv =====
// Top level of the command line parser: line state registers and result register.
// Depends on tclp_pkg, tclp_feed and tclp_judge.
//
//   channel | direction | payload              | request
//   in      | input     | in_item_t (byte)     | one byte of the line
//   out     | output    | out_item_t (verdict) | one verdict per line
//
// One byte is taken every cycle while in_ready is high; the byte's state update and, for the last byte
// of a line, the verdict are formed in the same cycle from the line registers.
// The verdict appears in the result register in the cycle after the last byte is taken.
// in_ready drops only while a finished verdict waits and out_ready is low.
// rst_n clears all line state and the result valid flag at once.
module text_command_line_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tclp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tclp_pkg::out_item_t out_data
);

    logic [tclp_pkg::COUNT_W-1:0] byte_count_reg;
    logic [tclp_pkg::COUNT_W-1:0] byte_count_next;
    logic [tclp_pkg::COUNT_W-1:0] kept_length_reg;
    logic [tclp_pkg::COUNT_W-1:0] kept_length_next;
    logic                         pending_reg;
    logic                         pending_next;
    tclp_pkg::parse_regs_t        live_reg;
    tclp_pkg::parse_regs_t        live_next;
    tclp_pkg::parse_regs_t        held_reg;
    tclp_pkg::parse_regs_t        held_next;
    tclp_pkg::parse_regs_t        fed;
    tclp_pkg::parse_regs_t        judged;
    tclp_pkg::out_item_t          verdict;
    logic                         out_valid_reg;
    tclp_pkg::out_item_t          out_data_reg;
    logic                         accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    tclp_feed u_feed (
        .cur (live_reg),
        .c   (in_data.data_byte),
        .nxt (fed)
    );

    tclp_judge u_judge (
        .s           (judged),
        .kept_length (kept_length_next),
        .verdict     (verdict)
    );

    always_comb
    begin
        byte_count_next = byte_count_reg;
        if (byte_count_reg < tclp_pkg::COUNT_W'(tclp_pkg::LINE_MAX)) begin
            byte_count_next = byte_count_reg + 1'b1;
        end
        kept_length_next = kept_length_reg;
        pending_next     = pending_reg;
        held_next        = held_reg;
        // A run of bytes at or below space may be trailing blanks, so the state
        // from before the run is kept for judging.
        if (in_data.data_byte > 8'h20) begin
            kept_length_next = byte_count_next;
            pending_next     = 1'b0;
        end else if (!pending_reg) begin
            held_next    = live_reg;
            pending_next = 1'b1;
        end
        live_next = fed;
        judged    = pending_next ? held_next : live_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_count_reg  <= '0;
            kept_length_reg <= '0;
            pending_reg     <= 1'b0;
            live_reg        <= '0;
            held_reg        <= '0;
        end else if (accept) begin
            if (in_data.line_end) begin
                byte_count_reg  <= '0;
                kept_length_reg <= '0;
                pending_reg     <= 1'b0;
                live_reg        <= '0;
                held_reg        <= '0;
            end else begin
                byte_count_reg  <= byte_count_next;
                kept_length_reg <= kept_length_next;
                pending_reg     <= pending_next;
                live_reg        <= live_next;
                held_reg        <= held_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept && in_data.line_end) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.line_end) begin
            out_data_reg <= verdict;
        end
    end

    a_fields_clear_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != tclp_pkg::ST_OK |->
            !out_data_reg.command_kind && !out_data_reg.screen_choice &&
            out_data_reg.tune_hz == '0)
        else $error("verdict with error status carries command fields");

    a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.line_end |=> out_valid_reg)
        else $error("no verdict after the last byte of a line");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.line_end |=>
            byte_count_reg == '0 && kept_length_reg == '0 && !pending_reg)
        else $error("line state not cleared after a verdict");

    a_kept_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        kept_length_reg <= byte_count_reg)
        else $error("kept length exceeds byte count");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg.hz_overflow |-> live_reg.hz_accumulator == '1)
        else $error("frequency overflow without saturated accumulator");

endmodule

// ===== bench/tclp_verdict_checker.sv =====
`timescale 1ns / 100ps
// Verdict checker for the command line parser: tracks every accepted byte,
// predicts the verdict of each line and compares it with the block's output.
// Depends on tclp_pkg for the payload types, status codes and parser phases.
module tclp_verdict_checker
    import tclp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        open_verdicts
);

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  hits;
        logic [5:0]  tok_len;
        logic        ended;
        logic        ovf;
        logic [3:0]  err;
        logic [31:0] acc;
    } scan_t;

    int        line_bytes;
    int        kept_len;
    logic      blank_run;
    scan_t     live_scan;
    scan_t     held_scan;
    out_item_t verdict_q[$];
    out_item_t want;
    int        verdict_num;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_decimal(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Keyword k of the command table (screen = 0) or of the screen table.
    function automatic int keyword_len(bit screen, bit k);
        return screen ? (k ? 6 : 5) : 4;
    endfunction

    function automatic logic [7:0] keyword_char(bit screen, bit k, int pos);
        logic [47:0] txt;
        int          n;
        n = keyword_len(screen, k);
        case ({screen, k})
            2'b00: txt = "view";
            2'b01: txt = "tune";
            2'b10: txt = "scope";
            default: txt = "survey";
        endcase
        return txt[8 * (n - 1 - pos) +: 8];
    endfunction

    function automatic scan_t narrow_hits(scan_t s, logic [7:0] c, bit screen);
        for (int k = 0; k < 2; k++)
        begin
            if (s.hits[k] && (s.tok_len >= keyword_len(screen, k[0])
                || keyword_char(screen, k[0], s.tok_len) != c))
                s.hits[k] = 1'b0;
        end
        if (s.tok_len < 6'd63)
            s.tok_len = s.tok_len + 6'd1;
        return s;
    endfunction

    function automatic int whole_match(scan_t s, bit screen);
        for (int k = 0; k < 2; k++)
        begin
            if (s.hits[k] && s.tok_len == keyword_len(screen, k[0]))
                return k;
        end
        return -1;
    endfunction

    // Only space and tab may separate the tune keyword from its number.
    function automatic scan_t tune_gap(scan_t s, logic [7:0] c);
        if (c == 8'h20 || c == 8'h09)
            return s;
        if (is_decimal(c))
        begin
            s.phase = PH_NUM;
            s.acc   = 32'(c - "0");
            s.ovf   = 1'b0;
        end
        else
            s.err = ST_NOT_INT;
        return s;
    endfunction

    function automatic scan_t scan_byte(scan_t s, logic [7:0] c);
        bit          sp;
        bit          scr;
        int          w;
        logic [35:0] wide;
        if (s.ended || s.err != ST_OK)
            return s;
        if (c == 8'h00)
        begin
            s.ended = 1'b1;
            return s;
        end
        sp = is_space(c);
        case (s.phase)
            PH_START, PH_VGAP:
                if (!sp)
                begin
                    scr       = (s.phase == PH_VGAP);
                    s.phase   = scr ? PH_SCREEN : PH_WORD;
                    s.tok_len = '0;
                    s.hits    = 2'b11;
                    s         = narrow_hits(s, c, scr);
                end
            PH_WORD:
                if (sp)
                begin
                    w = whole_match(s, 1'b0);
                    if (w == 0)
                        s.phase = PH_VGAP;
                    else if (w == 1)
                    begin
                        s.phase = PH_TGAP;
                        s       = tune_gap(s, c);
                    end
                    else
                        s.err = ST_BAD_CMD;
                end
                else
                    s = narrow_hits(s, c, 1'b0);
            PH_SCREEN:
                if (sp)
                    s.phase = PH_VTAIL;
                else if (s.tok_len >= TOKEN_MAX)
                    s.err = ST_TRAILING;
                else
                    s = narrow_hits(s, c, 1'b1);
            PH_TGAP:
                s = tune_gap(s, c);
            PH_NUM:
                if (is_decimal(c))
                begin
                    wide = {4'b0, s.acc} * 36'd10 + 36'(c - "0");
                    if (wide > 36'hFFFF_FFFF)
                    begin
                        s.acc = '1;
                        s.ovf = 1'b1;
                    end
                    else
                        s.acc = wide[31:0];
                end
                else if (sp)
                    s.phase = PH_NTAIL;
                else
                    s.err = ST_TRAILING;
            default:
                if (!sp)
                    s.err = ST_TRAILING;
        endcase
        return s;
    endfunction

    function automatic out_item_t line_verdict(scan_t s, int kept);
        out_item_t v;
        int        m;
        v = '0;
        if (kept == 0)
            v.status = ST_EMPTY;
        else if (kept >= LINE_MAX)
            v.status = ST_TOO_LONG;
        else if (s.err != ST_OK)
            v.status = s.err;
        else
        begin
            case (s.phase)
                PH_START:
                    v.status = ST_MALFORMED;
                PH_WORD:
                begin
                    m = whole_match(s, 1'b0);
                    v.status = (m == 0) ? ST_NO_SCREEN : (m == 1) ? ST_NO_FREQ : ST_BAD_CMD;
                end
                PH_VGAP:
                    v.status = ST_NO_SCREEN;
                PH_SCREEN, PH_VTAIL:
                begin
                    m = whole_match(s, 1'b1);
                    if (m < 0)
                        v.status = ST_BAD_SCREEN;
                    else
                        v.screen_choice = (m == 1);
                end
                PH_TGAP:
                    v.status = ST_NO_FREQ;
                default:
                    if (s.ovf)
                        v.status = ST_RANGE;
                    else
                    begin
                        v.command_kind = 1'b1;
                        v.tune_hz      = s.acc;
                    end
            endcase
        end
        return v;
    endfunction

    task automatic clear_line();
        line_bytes = 0;
        kept_len   = 0;
        blank_run  = 1'b0;
        live_scan  = '0;
        held_scan  = '0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        $display("%0t verdict %0d: %s got %0d, expected %0d",
                 $time, verdict_num, what, got, exp_val);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            verdict_q.delete();
            open_verdicts = 0;
            fail_count    = 0;
            verdict_num   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch("verdict with no line pending, status",
                                    32'(out_data.status), 0);
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(out_data.status), 32'(want.status));
                    if (out_data.command_kind !== want.command_kind)
                        report_mismatch("command_kind", 32'(out_data.command_kind),
                                        32'(want.command_kind));
                    if (out_data.screen_choice !== want.screen_choice)
                        report_mismatch("screen_choice", 32'(out_data.screen_choice),
                                        32'(want.screen_choice));
                    if (out_data.tune_hz !== want.tune_hz)
                        report_mismatch("tune_hz", out_data.tune_hz, want.tune_hz);
                end
                verdict_num++;
            end

            if (in_valid && in_ready)
            begin
                if (line_bytes < LINE_MAX)
                    line_bytes++;
                // The parse state at the last byte above 0x20 is the one judged.
                if (in_data.data_byte > 8'h20)
                begin
                    kept_len  = line_bytes;
                    blank_run = 1'b0;
                end
                else if (!blank_run)
                begin
                    held_scan = live_scan;
                    blank_run = 1'b1;
                end
                live_scan = scan_byte(live_scan, in_data.data_byte);
                if (in_data.line_end)
                begin
                    verdict_q.push_back(line_verdict(blank_run ? held_scan : live_scan,
                                                     kept_len));
                    clear_line();
                end
            end
            open_verdicts = verdict_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the command line parser: clock, reset, byte stimulus,
// output back-pressure, watchdog and final verdict.
// Depends on tclp_pkg, text_command_line_parser_core and tclp_verdict_checker.
module tb_top;

    import tclp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 250;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    int        fail_count;
    int        open_verdicts;
    int        byte_total  = 0;
    int        idle_cycles = 0;
    int        ready_left  = 0;
    int        ready_roll;
    bit        steady_line;
    logic [7:0] line_buf[$];

    always #5 clk = ~clk;

    text_command_line_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tclp_verdict_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .open_verdicts (open_verdicts)
    );

    // Verdict back-pressure: ready runs of random length, short stalls and a few long ones.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_left <= 0;
        end
        else if (ready_left == 0)
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 25)
            begin
                out_ready  <= 1'b0;
                ready_left <= (ready_roll < 3) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            end
            else
            begin
                out_ready  <= 1'b1;
                ready_left <= $urandom_range(1, 40);
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Called right after a rising edge; returns right after the edge that takes the byte.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        int r;
        gap = 0;
        if (!steady_line)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(8, 40);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, line_end: last};
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        byte_total++;
    endtask

    task automatic send_line();
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom_range(0, 255)));
        steady_line = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Blank kinds: 0 space or tab, 1 any whitespace, 2 any byte up to 0x20.
    task automatic push_blanks(int n, int kind);
        for (int i = 0; i < n; i++)
        begin
            if (kind == 0)
                line_buf.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
            else if (kind == 1)
                line_buf.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
            else
                line_buf.push_back(8'($urandom_range(0, 32)));
        end
    endtask

    task automatic push_word(int n);
        for (int i = 0; i < n; i++)
            line_buf.push_back($urandom_range(0, 4) ? 8'($urandom_range(8'h61, 8'h7A))
                                                    : 8'($urandom_range(8'h21, 8'hFF)));
    endtask

    task automatic push_digits(int n);
        for (int i = 0; i < n; i++)
            line_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
    endtask

    task automatic send_text(string s);
        push_text(s);
        send_line();
    endtask

    initial
    begin
        int choice;
        int pick;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: blank-only lines, every verdict and the parser's corner cases.
        line_buf.push_back(8'h20);
        send_line();
        line_buf.push_back(8'h00);
        send_line();
        send_text("view scope");
        push_text("  \tview\t survey ");
        line_buf.push_back(8'h0D);
        line_buf.push_back(8'h0A);
        send_line();
        send_text("tune 0");
        send_text("tune\t \t4294967295");
        send_text("tune 4294967296");
        send_text("tune 99999999999x");
        send_text("view   ");
        send_text("view sco");
        send_text("view scope extra");
        push_text("view ");
        repeat (31) line_buf.push_back("a");
        send_line();
        push_text("view ");
        repeat (32) line_buf.push_back("a");
        send_line();
        send_text("tune \t");
        send_text("tune\n5");
        send_text("tune 12a");
        send_text("tune 42 x");
        send_text("viewx scope");
        push_text("vi");
        line_buf.push_back(8'h01);
        send_text("ew scope");
        // A zero byte ends the text; what follows only counts toward the length.
        push_text("view");
        line_buf.push_back(8'h00);
        send_text("survey");
        push_text("tune 5");
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        send_line();
        line_buf.push_back(8'h00);
        send_text("a");
        repeat (255) line_buf.push_back("a");
        send_line();
        repeat (256) line_buf.push_back(8'hFF);
        send_line();
        push_text("view scope");
        push_blanks(40, 2);
        send_line();

        n = byte_total;
        while (byte_total < n + RANDOM_BYTES)
        begin
            choice = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                push_blanks($urandom_range(1, 3), 1);
            if (choice < 35)
            begin
                push_text("view");
                push_blanks($urandom_range(1, 3), 1);
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    push_text("scope");
                else if (pick < 8)
                    push_text("survey");
                else
                    push_word($urandom_range(1, 34));
                if ($urandom_range(0, 6) == 0)
                begin
                    push_blanks(1, 1);
                    push_word($urandom_range(1, 5));
                end
            end
            else if (choice < 70)
            begin
                push_text("tune");
                if ($urandom_range(0, 9) == 0)
                    line_buf.push_back($urandom_range(0, 1) ? 8'h0A : "x");
                else
                    push_blanks($urandom_range(1, 3), 0);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    push_digits($urandom_range(1, 9));
                else if (pick < 8)
                begin
                    // Ten digits straddle the top of the 32-bit range.
                    line_buf.push_back(8'($urandom_range(8'h33, 8'h35)));
                    push_digits(9);
                end
                else
                    push_digits($urandom_range(11, 13));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    push_word(1);
                else if (pick == 1)
                begin
                    push_blanks(1, 0);
                    push_word($urandom_range(1, 4));
                end
            end
            else if (choice < 85)
            begin
                repeat ($urandom_range(1, 20))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if (choice < 98)
            begin
                // Near miss on a keyword.
                pick = line_buf.size();
                push_text($urandom_range(0, 1) ? "view" : "tune");
                if ($urandom_range(0, 2) == 0)
                    push_word(1);
                else
                    line_buf[pick + $urandom_range(0, 3)] = 8'($urandom_range(8'h21, 8'h7E));
                push_blanks(1, 0);
                if ($urandom_range(0, 1))
                    push_text("scope");
                else
                    push_digits($urandom_range(1, 5));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    push_word($urandom_range(250, 300));
                else
                begin
                    push_text("view survey");
                    push_blanks($urandom_range(240, 260), 1);
                end
            end
            if ($urandom_range(0, 2) == 0)
                push_blanks($urandom_range(1, 4), 2);
            if ($urandom_range(0, 19) == 0 && line_buf.size() > 0)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'h00;
            send_line();
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (open_verdicts != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        if (fail_count == 0 && open_verdicts == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tclp_pkg.sv
hw/rtl/tclp_feed.sv
hw/rtl/tclp_judge.sv
hw/rtl/text_command_line_parser_core.sv
bench/tclp_verdict_checker.sv
bench/tb_top.sv
